// ===== rtl/rsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI threshold signal package
// Shared sizes, register indexes, threshold defaults and datapath types.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int PRICE_BITS = 32;

  localparam int IDX_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 2);
  localparam int DIFF_W = PRICE_BITS + 1;
  localparam int SUM_W  = PRICE_BITS + IDX_W;
  localparam int DEN_W  = SUM_W + 1;
  localparam int WL_W   = 7;
  localparam int THR_W  = 15;
  localparam int PROD_W = DEN_W + THR_W;

  localparam logic [WL_W-1:0]  DEFAULT_WINDOW = 7'd14;
  localparam logic [THR_W-1:0] DEFAULT_LOW    = 15'd7680;
  localparam logic [THR_W-1:0] DEFAULT_HIGH   = 15'd17920;
  localparam logic [THR_W-1:0] FULL_SCALE     = 15'd25600;

  localparam logic [1:0] SIG_NONE = 2'b00;
  localparam logic [1:0] SIG_BUY  = 2'b01;
  localparam logic [1:0] SIG_SELL = 2'b11;
  localparam logic [3:0] MARKER_OFF = 4'd0;
  localparam logic [3:0] MARKER_ON  = 4'd10;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_LOW    = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;

  // Gain and loss magnitudes of one price difference.
  typedef struct packed {
    logic [PRICE_BITS-1:0] gain;
    logic [PRICE_BITS-1:0] loss;
  } mag_t;

  // Gain and loss sums over a run of differences.
  typedef struct packed {
    logic [SUM_W-1:0] gain;
    logic [SUM_W-1:0] loss;
  } pair_t;

  // Load enables of the sum, ratio and multiply stages.
  typedef struct packed {
    logic s3_en;
    logic s4_en;
    logic s5_en;
  } pipe_ctrl_t;

endpackage

// ===== rtl/rsi_threshold_signal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI threshold signal
// Per-bar RSI from windowed gain and loss sums, compared with two thresholds.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_*      slave      tdata[31:0] close_price
//  out_*     master     tdata[1:0] signal, tdata[5:2] marker_size
//  cfg_*     write      index 0 window_length, 1 low_threshold, 2 high_threshold
//
// One bar is accepted every cycle unless a stalled output backs up the
// pipeline; the prefix cell row updates all window sums in the cycle a bar
// is taken, after the first bar. A result passes through window extent,
// select, sum, ratio, multiply and compare stages. Reset clears the counters
// and loads the register defaults; the cells need no clearing pass. A stalled
// output holds its stage, and bars keep being taken while any stage ahead of it is empty.
module rsi_threshold_signal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // close_price[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // signal[1:0], marker_size[5:2], zero[7:6]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int PB = rsi_pkg::PRICE_BITS;
  localparam int CW = rsi_pkg::CNT_W;

  // Configuration registers.
  logic [rsi_pkg::WL_W-1:0]  wl_r;
  logic [rsi_pkg::THR_W-1:0] low_r, high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= rsi_pkg::DEFAULT_WINDOW;
      low_r  <= rsi_pkg::DEFAULT_LOW;
      high_r <= rsi_pkg::DEFAULT_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        rsi_pkg::REG_WINDOW: wl_r   <= cfg_data[rsi_pkg::WL_W-1:0];
        rsi_pkg::REG_LOW:    low_r  <= cfg_data[rsi_pkg::THR_W-1:0];
        rsi_pkg::REG_HIGH:   high_r <= cfg_data[rsi_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic take1, take2, take3, take4, take5, take_out;
  logic accept;

  assign take_out  = !out_v_r || out_tready;
  assign take5     = !v5_r || take_out;
  assign take4     = !v4_r || take5;
  assign take3     = !v3_r || take4;
  assign take2     = !v2_r || take3;
  assign take1     = !v1_r || take2;
  assign in_tready = take1;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (take1)    v1_r    <= accept;
      if (take2)    v2_r    <= v1_r;
      if (take3)    v3_r    <= v2_r;
      if (take4)    v4_r    <= v3_r;
      if (take5)    v5_r    <= v4_r;
      if (take_out) out_v_r <= v5_r;
    end
  end

  // Bar history.
  logic [PB-1:0]            price, prev_r;
  logic [CW-1:0]            bars_r, bars_nxt;
  logic [rsi_pkg::DIFF_W-1:0] diff, diff_abs;
  rsi_pkg::mag_t            mag, fd_r;
  logic                     shift_en;

  assign price    = in_tdata[PB-1:0];
  assign diff     = {1'b0, price} - {1'b0, prev_r};
  assign diff_abs = diff[rsi_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign mag.gain = diff[rsi_pkg::DIFF_W-1] ? '0 : diff_abs[PB-1:0];
  assign mag.loss = diff[rsi_pkg::DIFF_W-1] ? diff_abs[PB-1:0] : '0;
  assign bars_nxt = (bars_r < CW'(rsi_pkg::WINDOW_MAX + 1)) ? bars_r + 1'b1 : bars_r;
  assign shift_en = accept && (bars_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bars_r <= '0;
      prev_r <= '0;
      fd_r   <= '0;
    end else if (accept) begin
      bars_r <= bars_nxt;
      prev_r <= price;
      if (bars_r == CW'(1)) begin
        fd_r <= mag;
      end
    end
  end

  // Window extent of the bar being taken.
  logic [CW-1:0]             n_eff, last, real_len, pad_len;
  logic [rsi_pkg::IDX_W-1:0] sel;
  logic                      is_short;

  always_comb begin
    if (wl_r < rsi_pkg::WL_W'(2)) begin
      n_eff = CW'(rsi_pkg::DEFAULT_WINDOW);
    end else if (32'(wl_r) > rsi_pkg::WINDOW_MAX) begin
      n_eff = CW'(rsi_pkg::WINDOW_MAX);
    end else begin
      n_eff = CW'(wl_r);
    end
    last     = bars_nxt - 1'b1;
    is_short = last < CW'(2);
    real_len = (n_eff < last) ? n_eff : last;
    pad_len  = n_eff - real_len;
    sel      = rsi_pkg::IDX_W'(real_len - 1'b1);
  end

  logic [rsi_pkg::IDX_W-1:0] s1_sel_r;
  logic [CW-1:0]             s1_pad_r;
  logic                      s1_short_r;

  always_ff @(posedge clk) begin
    if (take1) begin
      s1_sel_r   <= sel;
      s1_pad_r   <= pad_len;
      s1_short_r <= is_short;
    end
  end

  rsi_pkg::pair_t sel_sum;

  rsi_chain u_chain (
    .clk      (clk),
    .shift_en (shift_en),
    .mag_in   (mag),
    .sel      (s1_sel_r),
    .sel_sum  (sel_sum)
  );

  // Select stage: windowed prefix and the first difference standing in for
  // differences older than the first bar.
  rsi_pkg::pair_t s2_prefix_r, s2_pad_r;
  logic           s2_short_r;

  always_ff @(posedge clk) begin
    if (take2) begin
      s2_prefix_r   <= sel_sum;
      s2_pad_r.gain <= rsi_pkg::SUM_W'(s1_pad_r) * rsi_pkg::SUM_W'(fd_r.gain);
      s2_pad_r.loss <= rsi_pkg::SUM_W'(s1_pad_r) * rsi_pkg::SUM_W'(fd_r.loss);
      s2_short_r    <= s1_short_r;
    end
  end

  rsi_pkg::pipe_ctrl_t ctrl;
  logic [1:0]          sig;

  assign ctrl.s3_en = take3;
  assign ctrl.s4_en = take4;
  assign ctrl.s5_en = take5;

  rsi_judge u_judge (
    .clk       (clk),
    .ctrl      (ctrl),
    .prefix_in (s2_prefix_r),
    .pad_in    (s2_pad_r),
    .short_in  (s2_short_r),
    .low_thr   (low_r),
    .high_thr  (high_r),
    .sig_o     (sig)
  );

  logic [7:0] out_data_r;

  always_ff @(posedge clk) begin
    if (take_out) begin
      out_data_r <= {2'b00, (sig == rsi_pkg::SIG_NONE) ? rsi_pkg::MARKER_OFF
                                                      : rsi_pkg::MARKER_ON, sig};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // The bar counter saturates one above the window maximum.
  a_bars_sat: assert property (@(posedge clk) disable iff (!rst_n)
    bars_r <= CW'(rsi_pkg::WINDOW_MAX + 1))
    else $error("bar counter out of range");

  // A full window splits into stored differences plus padding.
  a_window_split: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !s1_short_r) |-> (CW'(s1_sel_r) + s1_pad_r + CW'(1) == n_eff))
    else $error("window split does not add up to the window length");

  // Marker and signal agree on every result.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[1:0] == rsi_pkg::SIG_NONE) == (out_tdata[5:2] == '0)))
    else $error("marker size disagrees with signal");

  // The first bar leaves the cell row untouched.
  a_first_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && bars_r == '0) |-> !shift_en)
    else $error("cells shifted without a price difference");

endmodule

// ===== rtl/rsi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI prefix cell
// Holds the gain and loss sums of the newest differences up to its own age.
// ----------------------------------------------------------------------------
module rsi_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  rsi_pkg::mag_t  mag_in,
  input  rsi_pkg::pair_t prev_in,
  output rsi_pkg::pair_t sum_o
);

  rsi_pkg::pair_t sum_r;
  rsi_pkg::pair_t sum_nxt;

  // The new difference becomes age zero, so this cell takes its neighbor's
  // sum, one age younger, plus the new difference.
  always_comb begin
    sum_nxt.gain = rsi_pkg::SUM_W'(mag_in.gain) + prev_in.gain;
    sum_nxt.loss = rsi_pkg::SUM_W'(mag_in.loss) + prev_in.loss;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

// ===== rtl/rsi_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI prefix chain
// A row of prefix cells; the selected cell gives the window sums.
// ----------------------------------------------------------------------------
module rsi_chain (
  input  logic                      clk,
  input  logic                      shift_en,
  input  rsi_pkg::mag_t              mag_in,
  input  logic [rsi_pkg::IDX_W-1:0] sel,
  output rsi_pkg::pair_t             sel_sum
);

  rsi_pkg::pair_t sums    [rsi_pkg::WINDOW_MAX];
  rsi_pkg::pair_t chain_in[rsi_pkg::WINDOW_MAX];

  assign chain_in[0] = '0;

  for (genvar k = 0; k < rsi_pkg::WINDOW_MAX; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign chain_in[k] = sums[k-1];
    end
    rsi_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .mag_in   (mag_in),
      .prev_in  (chain_in[k]),
      .sum_o    (sums[k])
    );
  end

  assign sel_sum = sums[sel];

endmodule

// ===== rtl/rsi_judge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI judge
// Forms up and down sums, cross-multiplies with the thresholds and compares.
// ----------------------------------------------------------------------------
module rsi_judge (
  input  logic                      clk,
  input  rsi_pkg::pipe_ctrl_t        ctrl,
  input  rsi_pkg::pair_t             prefix_in,
  input  rsi_pkg::pair_t             pad_in,
  input  logic                      short_in,
  input  logic [rsi_pkg::THR_W-1:0] low_thr,
  input  logic [rsi_pkg::THR_W-1:0] high_thr,
  output logic [1:0]                sig_o
);

  logic [rsi_pkg::SUM_W-1:0]  up_r, dn_r;
  logic [rsi_pkg::DEN_W-1:0]  num_r, den_r;
  logic [rsi_pkg::PROD_W-1:0] lhs_r, rlo_r, rhi_r;
  logic                       s3_short_r, s4_short_r, s5_short_r;

  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      up_r       <= prefix_in.gain + pad_in.gain;
      dn_r       <= prefix_in.loss + pad_in.loss;
      s3_short_r <= short_in;
    end
    if (ctrl.s4_en) begin
      // With no losses the ratio is taken as exactly one.
      if (dn_r == '0) begin
        num_r <= rsi_pkg::DEN_W'(1);
        den_r <= rsi_pkg::DEN_W'(1);
      end else begin
        num_r <= rsi_pkg::DEN_W'(up_r);
        den_r <= rsi_pkg::DEN_W'(up_r) + rsi_pkg::DEN_W'(dn_r);
      end
      s4_short_r <= s3_short_r;
    end
    if (ctrl.s5_en) begin
      lhs_r      <= rsi_pkg::PROD_W'(num_r) * rsi_pkg::PROD_W'(rsi_pkg::FULL_SCALE);
      rlo_r      <= rsi_pkg::PROD_W'(den_r) * rsi_pkg::PROD_W'(low_thr);
      rhi_r      <= rsi_pkg::PROD_W'(den_r) * rsi_pkg::PROD_W'(high_thr);
      s5_short_r <= s4_short_r;
    end
  end

  always_comb begin
    if (s5_short_r) begin
      sig_o = rsi_pkg::SIG_NONE;
    end else if (lhs_r < rlo_r) begin
      sig_o = rsi_pkg::SIG_BUY;
    end else if (lhs_r > rhi_r) begin
      sig_o = rsi_pkg::SIG_SELL;
    end else begin
      sig_o = rsi_pkg::SIG_NONE;
    end
  end

endmodule

// ===== test/rsi_signal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI threshold signal checker
// Watches the bar, result and register ports of the block. It keeps its own
// copy of the price history and the registers, works out the signal of
// every accepted bar, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module rsi_signal_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // close_price[31:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // signal[1:0], marker_size[5:2], zero[7:6]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned results_checked,
  output int unsigned buys,
  output int unsigned sells
);

  typedef struct packed {
    logic [1:0] sig;
    logic [3:0] mark;
  } bar_signal_t;

  bar_signal_t awaited_signals[$];

  logic [rsi_pkg::WL_W-1:0]          window_reg;
  logic [rsi_pkg::THR_W-1:0]         low_reg;
  logic [rsi_pkg::THR_W-1:0]         high_reg;
  logic [rsi_pkg::PRICE_BITS-1:0]    prev_price;
  int unsigned                       bars_seen;
  logic signed [rsi_pkg::DIFF_W-1:0] first_diff;
  logic signed [rsi_pkg::DIFF_W-1:0] diff_ring [rsi_pkg::WINDOW_MAX];
  logic [rsi_pkg::IDX_W-1:0]         ring_head;

  // Adds one bar to the history and returns the signal that it produces.
  function automatic bar_signal_t signal_of_bar(
    input logic [rsi_pkg::PRICE_BITS-1:0] price
  );
    logic signed [rsi_pkg::DIFF_W-1:0] d;
    logic [rsi_pkg::IDX_W-1:0]         pos;
    int unsigned              n;
    int unsigned              hist;
    int unsigned              span;
    int unsigned              k;
    longint                   step;
    longint unsigned          gains;
    longint unsigned          losses;
    longint unsigned          num;
    longint unsigned          den;
    bar_signal_t              v;
    v.sig  = rsi_pkg::SIG_NONE;
    v.mark = rsi_pkg::MARKER_OFF;
    gains  = 0;
    losses = 0;
    if (bars_seen >= 1) begin
      d = $signed({1'b0, price}) - $signed({1'b0, prev_price});
      if (bars_seen == 1) first_diff = d;
      diff_ring[ring_head] = d;
      ring_head = ring_head + 1'b1;
    end
    prev_price = price;
    if (bars_seen < rsi_pkg::WINDOW_MAX + 1) bars_seen++;
    if (bars_seen < 3) return v;

    hist = bars_seen - 1;
    n = 32'(window_reg);
    if (n < 2) n = 32'(rsi_pkg::DEFAULT_WINDOW);
    if (n > rsi_pkg::WINDOW_MAX) n = rsi_pkg::WINDOW_MAX;
    span = (n < hist) ? n : hist;
    // Window slots older than the stored history reuse the first difference.
    for (k = 0; k < n; k++) begin
      if (k < span) begin
        pos  = rsi_pkg::IDX_W'(ring_head - 1 - k);
        step = 64'(diff_ring[pos]);
      end else begin
        step = 64'(first_diff);
      end
      if (step < 0) losses += -step;
      else gains += step;
    end

    // With no losses the RSI is exactly 100, so the ratio becomes 1/1.
    if (losses == 0) begin
      num = 1;
      den = 1;
    end else begin
      num = gains;
      den = gains + losses;
    end
    if (num * rsi_pkg::FULL_SCALE < den * low_reg) v.sig = rsi_pkg::SIG_BUY;
    else if (num * rsi_pkg::FULL_SCALE > den * high_reg) v.sig = rsi_pkg::SIG_SELL;
    if (v.sig != rsi_pkg::SIG_NONE) v.mark = rsi_pkg::MARKER_ON;
    return v;
  endfunction

  always @(posedge clk) begin
    bar_signal_t want;
    if (!rst_n) begin
      awaited_signals.delete();
      window_reg      = rsi_pkg::DEFAULT_WINDOW;
      low_reg         = rsi_pkg::DEFAULT_LOW;
      high_reg        = rsi_pkg::DEFAULT_HIGH;
      prev_price      = '0;
      bars_seen       = 0;
      first_diff      = '0;
      ring_head       = '0;
      mismatches      = 0;
      results_checked = 0;
      buys            = 0;
      sells           = 0;
      for (int i = 0; i < rsi_pkg::WINDOW_MAX; i++) diff_ring[i] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rsi_pkg::REG_WINDOW: window_reg = cfg_data[rsi_pkg::WL_W-1:0];
          rsi_pkg::REG_LOW:    low_reg    = cfg_data;
          rsi_pkg::REG_HIGH:   high_reg   = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) awaited_signals.push_back(signal_of_bar(in_tdata));

      if (out_tvalid && out_tready) begin
        if (awaited_signals.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction: expected none, got %h",
                   $time, out_tdata);
        end else begin
          want = awaited_signals.pop_front();
          results_checked++;
          if (want.sig == rsi_pkg::SIG_BUY) buys++;
          if (want.sig == rsi_pkg::SIG_SELL) sells++;
          if (out_tdata[1:0] !== want.sig || out_tdata[5:2] !== want.mark ||
              out_tdata[7:6] !== 2'b00) begin
            mismatches++;
            $display("%0t: result %0d: expected sig %b mark %0d pad 00, got %b %0d %b",
                     $time, results_checked, want.sig, want.mark,
                     out_tdata[1:0], out_tdata[5:2], out_tdata[7:6]);
          end
        end
      end
    end
    pending = awaited_signals.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI threshold signal testbench
// Drives closing prices through the block under a series of register
// settings, with random gaps and stalls on both channels; the checker
// beside the block predicts every signal and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int unsigned BAR_TARGET  = 1600;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [31:0] PRICE_MAX   = 32'hffff_ffff;

  typedef enum {STYLE_WALK, STYLE_NOISE, STYLE_EXTREMES} price_style_t;
  typedef enum {FLOW_RANDOM, FLOW_STEADY, FLOW_HOLD} flow_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned buys;
  int unsigned sells;

  bit          steady;
  bit          no_gaps;
  bit          hold_req;
  int unsigned bars_sent;
  int unsigned settings_used;
  logic [31:0] walk_price;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rsi_threshold_signal dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rsi_signal_checker rsi_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .buys            (buys),
    .sells           (sells)
  );

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [6:0] window, input logic [14:0] lo,
                           input logic [14:0] hi);
    write_reg(rsi_pkg::REG_WINDOW, {8'd0, window});
    write_reg(rsi_pkg::REG_LOW, lo);
    write_reg(rsi_pkg::REG_HIGH, hi);
    settings_used++;
  endtask

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_bar(input logic [31:0] price);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    bars_sent++;
  endtask

  // Lowers the bar channel and waits until every result has come back.
  task automatic end_phase();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [31:0] next_price(input price_style_t style,
                                             input int unsigned scale,
                                             input int unsigned lean);
    logic [31:0] step;
    case (style)
      STYLE_WALK: begin
        step = $urandom_range(0, scale);
        if ($urandom_range(0, 99) < lean) begin
          if (walk_price > PRICE_MAX - step) walk_price = PRICE_MAX;
          else walk_price = walk_price + step;
        end else begin
          if (walk_price < step) walk_price = '0;
          else walk_price = walk_price - step;
        end
      end
      STYLE_NOISE: walk_price = $urandom;
      default: begin
        if ($urandom_range(0, 9) < 7) walk_price = $urandom_range(0, 1) ? PRICE_MAX : '0;
      end
    endcase
    return walk_price;
  endfunction

  function automatic logic [14:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return 15'd0;
      1:       return rsi_pkg::FULL_SCALE;
      2:       return 15'h7fff;
      3:       return 15'd12800;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [6:0] pick_window();
    if ($urandom_range(0, 1)) return 7'($urandom_range(0, 127));
    case ($urandom_range(0, 8))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd3;
      4:       return rsi_pkg::DEFAULT_WINDOW;
      5:       return 7'd63;
      6:       return 7'd64;
      7:       return 7'd65;
      default: return 7'd127;
    endcase
  endfunction

  // Result side: random stalls, stall-free stretches and one long hold-off
  // on request, counted here while the sender keeps offering bars.
  initial begin
    int unsigned r;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_tready <= 1'b1;
        end else if (r < 95) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int unsigned  phase;
    int unsigned  len;
    int unsigned  scale;
    int unsigned  lean;
    logic [14:0]  lo;
    logic [14:0]  hi;
    price_style_t style;
    flow_t        flow;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = rsi_pkg::REG_WINDOW;
    cfg_data      = '0;
    steady        = 1'b0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    bars_sent     = 0;
    settings_used = 0;
    walk_price    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Defaults, after a write to an index that holds no register. The first
    // two bars give no signal; the window then reaches back before the first
    // difference, and the swings are as large as the price allows.
    write_reg(REG_UNUSED, 15'h7fff);
    send_bar(32'h0000_0000);
    send_bar(PRICE_MAX);
    send_bar(32'h0000_0000);
    send_bar(32'h0000_0000);
    send_bar(32'h8000_0000);
    send_bar(32'h8000_0001);
    send_bar(32'h7fff_ffff);
    send_bar(32'h7fff_ffff);
    end_phase();

    // A window below two acts as the default; zero thresholds.
    configure(7'd1, 15'd0, 15'd0);
    send_bar(32'h7fff_ffff);
    send_bar(32'h7fff_fff0);
    send_bar(32'h7fff_fff0);
    send_bar(32'h0000_0001);
    end_phase();

    // Thresholds above 100.0 are compared as they stand.
    configure(7'd2, 15'h7fff, 15'h7fff);
    send_bar(32'h0000_0001);
    send_bar(32'h0000_0001);
    send_bar(PRICE_MAX);
    send_bar(32'h0000_0000);
    end_phase();

    // Oversized window, and both thresholds at exactly 100.0 so that a
    // window without losses sits on the boundary.
    configure(7'd127, rsi_pkg::FULL_SCALE, rsi_pkg::FULL_SCALE);
    send_bar(32'h0000_0000);
    send_bar(32'h0000_0000);
    send_bar(32'h0000_0100);
    send_bar(32'h0000_0080);
    end_phase();

    phase = 0;
    while (bars_sent < BAR_TARGET) begin
      if ($urandom_range(0, 9) < 6) begin
        lo = 15'($urandom_range(0, 12800));
        hi = 15'($urandom_range(lo, 25600));
      end else begin
        lo = pick_threshold();
        hi = pick_threshold();
      end
      configure(pick_window(), lo, hi);

      if (phase == 1) flow = FLOW_HOLD;
      else case ($urandom_range(0, 9))
        0, 1:    flow = FLOW_STEADY;
        2:       flow = FLOW_HOLD;
        default: flow = FLOW_RANDOM;
      endcase
      steady  = (flow == FLOW_STEADY);
      no_gaps = (flow != FLOW_RANDOM);
      if (flow == FLOW_HOLD) hold_req = 1'b1;

      case ($urandom_range(0, 9))
        7, 8:    style = STYLE_NOISE;
        9:       style = STYLE_EXTREMES;
        default: style = STYLE_WALK;
      endcase
      case ($urandom_range(0, 4))
        0:       scale = 1;
        1:       scale = 16;
        2:       scale = 4096;
        3:       scale = 32'h0010_0000;
        default: scale = 32'h8000_0000;
      endcase
      lean = $urandom_range(5, 95);
      if ($urandom_range(0, 1)) walk_price = $urandom;
      len = (flow == FLOW_HOLD) ? $urandom_range(40, 80) : $urandom_range(20, 120);

      for (int i = 0; i < len; i++) send_bar(next_price(style, scale, lean));
      end_phase();
      steady  = 1'b0;
      no_gaps = 1'b0;
      phase++;
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d bars under %0d register settings; %0d results checked.",
             bars_sent, settings_used, results_checked);
    $display("Expected signals seen: %0d buy, %0d sell.", buys, sells);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
